FILE: hdl/rrsg_pkg.sv
// Shared constants, types and register codes of the rounded box span generator.
package rrsg_pkg;

	localparam int CW    = 16;
	localparam int FB    = 4;
	localparam int ROW_W = 12;
	localparam int NREG  = 7;
	localparam int IDX_W = 3;

	// Half-LSB sample coordinates need room for twice the box size and the row position.
	localparam int Y2W = ROW_W + FB + 1;
	localparam int HW  = ((Y2W > CW + 1) ? Y2W : CW + 1) + 1;
	localparam int EW  = CW + 2;

	localparam int DCW = $clog2(2 * CW);
	localparam int LAT = CW + 2;

	localparam int FQ_DEPTH = 4;
	localparam int FQW      = 2;
	localparam int DEPTH    = 32;
	localparam int DPW      = 5;

	localparam logic [IDX_W-1:0] REG_BOX_W  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_BOX_H  = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_RAD_TL = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_RAD_TR = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_RAD_BR = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_RAD_BL = IDX_W'(5);
	localparam logic [IDX_W-1:0] REG_BORDER = IDX_W'(6);

	// Corner order of the radius sets.
	localparam int TL = 0;
	localparam int TR = 1;
	localparam int BR = 2;
	localparam int BL = 3;

	// Edge lanes of one row.
	localparam int L_OL = 0;
	localparam int L_OR = 1;
	localparam int L_IL = 2;
	localparam int L_IR = 3;

	typedef logic [CW-1:0] coord_t;
	typedef logic [3:0][CW-1:0] quad_t;

	typedef struct packed {
		coord_t w;
		coord_t h;
		quad_t  req;
		coord_t bw;
	} cfg_t;

	typedef struct packed {
		logic  ready;
		quad_t outer;
		quad_t inner;
	} shape_t;

	typedef struct packed {
		logic  drop;
		logic  single;
		quad_t r2;
		quad_t dy;
	} job_t;

endpackage

FILE: hdl/rrsg_norm.sv
// Radius normalizer: scales and clamps the outer and inner corner radii after a register write.
module rrsg_norm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  rrsg_pkg::cfg_t   cfg,
	output rrsg_pkg::shape_t shape
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;
	localparam logic [1:0] ST_DIV  = 2'd3;

	logic [1:0]                 state_q;
	logic                       phase_q;
	logic [1:0]                 idx_q;
	logic [rrsg_pkg::DCW-1:0]   cnt_q;
	rrsg_pkg::quad_t            outer_q;
	rrsg_pkg::quad_t            inner_q;
	logic                       ready_q;

	logic [rrsg_pkg::CW-1:0]    num_q;
	logic [rrsg_pkg::CW:0]      den_q;
	logic [2*rrsg_pkg::CW-1:0]  dvd_q;
	logic [rrsg_pkg::CW:0]      rem_q;

	logic [rrsg_pkg::CW:0]      bw2;
	logic                       collapsed;
	rrsg_pkg::coord_t           sw;
	rrsg_pkg::coord_t           sh;
	rrsg_pkg::quad_t            src;
	logic [rrsg_pkg::CW:0]      sum;
	rrsg_pkg::coord_t           side;
	logic [2*rrsg_pkg::CW:0]    prod_a;
	logic [2*rrsg_pkg::CW:0]    prod_b;
	logic                       less;
	rrsg_pkg::coord_t           rmax;
	rrsg_pkg::coord_t           r_cur;
	logic                       scale;
	logic [rrsg_pkg::CW+1:0]    t;
	logic                       ge;
	logic [rrsg_pkg::CW:0]      rem_n;
	rrsg_pkg::coord_t           q_fin;
	logic                       store;
	rrsg_pkg::coord_t           stval;
	logic                       div_end;

	always_comb begin
		bw2       = {cfg.bw, 1'b0};
		collapsed = ({1'b0, cfg.w} <= bw2) || ({1'b0, cfg.h} <= bw2);
		if (phase_q) begin
			sw = rrsg_pkg::CW'({1'b0, cfg.w} - bw2);
			sh = rrsg_pkg::CW'({1'b0, cfg.h} - bw2);
		end else begin
			sw = cfg.w;
			sh = cfg.h;
		end
		for (int i = 0; i < 4; i++) begin
			if (phase_q) begin
				src[i] = (outer_q[i] > cfg.bw) ? outer_q[i] - cfg.bw : '0;
			end else begin
				src[i] = cfg.req[i];
			end
		end
		case (idx_q)
			2'd0: begin
				sum  = {1'b0, src[rrsg_pkg::TL]} + {1'b0, src[rrsg_pkg::TR]};
				side = sw;
			end
			2'd1: begin
				sum  = {1'b0, src[rrsg_pkg::BL]} + {1'b0, src[rrsg_pkg::BR]};
				side = sw;
			end
			2'd2: begin
				sum  = {1'b0, src[rrsg_pkg::TL]} + {1'b0, src[rrsg_pkg::BL]};
				side = sh;
			end
			default: begin
				sum  = {1'b0, src[rrsg_pkg::TR]} + {1'b0, src[rrsg_pkg::BR]};
				side = sh;
			end
		endcase
		// Exact ratio compare: side/sum < num/den by cross multiplication.
		prod_a = (2*rrsg_pkg::CW+1)'(side) * (2*rrsg_pkg::CW+1)'(den_q);
		prod_b = (2*rrsg_pkg::CW+1)'(num_q) * (2*rrsg_pkg::CW+1)'(sum);
		less   = prod_a < prod_b;
		rmax   = ((sw < sh) ? sw : sh) >> 1;
		r_cur  = src[idx_q];
		scale  = {1'b0, num_q} < den_q;
		t      = {rem_q, dvd_q[2*rrsg_pkg::CW-1]};
		ge     = t >= (rrsg_pkg::CW+2)'(den_q);
		rem_n  = ge ? (rrsg_pkg::CW+1)'(t - (rrsg_pkg::CW+2)'(den_q)) : t[rrsg_pkg::CW:0];
		q_fin  = {dvd_q[rrsg_pkg::CW-2:0], ge};
		div_end = cnt_q == rrsg_pkg::DCW'(2*rrsg_pkg::CW-1);
		store  = ((state_q == ST_LOAD) && !scale) || ((state_q == ST_DIV) && div_end);
		if (state_q == ST_LOAD) begin
			stval = (r_cur < rmax) ? r_cur : rmax;
		end else begin
			stval = (q_fin < rmax) ? q_fin : rmax;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
			idx_q   <= '0;
			cnt_q   <= '0;
			outer_q <= '0;
			inner_q <= '0;
			ready_q <= 1'b1;
		end else if (start) begin
			state_q <= ST_CMP;
			phase_q <= 1'b0;
			idx_q   <= '0;
			ready_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CMP: begin
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (scale) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + rrsg_pkg::DCW'(1);
				end
				default: begin
				end
			endcase
			if (store) begin
				if (phase_q) begin
					inner_q[idx_q] <= stval;
				end else begin
					outer_q[idx_q] <= stval;
				end
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					if (!phase_q && !collapsed) begin
						phase_q <= 1'b1;
						state_q <= ST_CMP;
					end else begin
						// A box that the border eats up has no inner corners.
						if (!phase_q) begin
							inner_q <= '0;
						end
						ready_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end else begin
					state_q <= ST_LOAD;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start || (store && idx_q == 2'd3)) begin
			num_q <= rrsg_pkg::CW'(1);
			den_q <= (rrsg_pkg::CW+1)'(1);
		end else if (state_q == ST_CMP && sum != '0 && less) begin
			num_q <= side;
			den_q <= sum;
		end
		if (state_q == ST_LOAD) begin
			dvd_q <= (2*rrsg_pkg::CW)'(r_cur) * (2*rrsg_pkg::CW)'(num_q);
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[2*rrsg_pkg::CW-2:0], ge};
			rem_q <= rem_n;
		end
	end

	assign shape.ready = ready_q;
	assign shape.outer = outer_q;
	assign shape.inner = inner_q;

endmodule

FILE: hdl/rrsg_front.sv
// Front end: takes row requests, classifies the corner band of each edge and queues the job.
module rrsg_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [rrsg_pkg::ROW_W-1:0]  row,
	input  logic                        kind,
	output logic                        full,
	input  rrsg_pkg::cfg_t              cfg,
	input  rrsg_pkg::shape_t            shape,
	input  logic                        deq,
	output logic                        avail,
	output rrsg_pkg::job_t              job
);

	typedef struct packed {
		rrsg_pkg::coord_t r2;
		rrsg_pkg::coord_t dy;
	} lane_t;

	rrsg_pkg::job_t           fq_q [rrsg_pkg::FQ_DEPTH];
	logic [rrsg_pkg::FQW-1:0] wr_q;
	logic [rrsg_pkg::FQW-1:0] rd_q;
	logic [rrsg_pkg::FQW:0]   cnt_q;

	logic [rrsg_pkg::HW-1:0]  y2;
	logic [rrsg_pkg::HW-1:0]  rowfx;
	logic [rrsg_pkg::HW-1:0]  bw2;
	logic [rrsg_pkg::HW-1:0]  ih;
	logic [rrsg_pkg::HW-1:0]  iy2;
	logic                     collapsed;
	logic                     acc;
	rrsg_pkg::job_t           cls;
	lane_t                    lanes [4];

	// Picks the corner whose band holds the sample line; r2 is zero outside both bands.
	function automatic lane_t band(rrsg_pkg::coord_t a, rrsg_pkg::coord_t b,
			logic [rrsg_pkg::HW-1:0] hh, logic [rrsg_pkg::HW-1:0] yy);
		logic [rrsg_pkg::HW-1:0] a2;
		logic [rrsg_pkg::HW-1:0] b2;
		logic [rrsg_pkg::HW-1:0] lim;
		logic [rrsg_pkg::HW-1:0] d;
		lane_t l;
		a2   = rrsg_pkg::HW'(a) << 1;
		b2   = rrsg_pkg::HW'(b) << 1;
		lim  = (hh << 1) - b2;
		l.r2 = '0;
		d    = '0;
		if (a != '0 && yy < a2) begin
			l.r2 = rrsg_pkg::CW'(a2);
			d    = a2 - yy;
		end else if (b != '0 && yy > lim) begin
			l.r2 = rrsg_pkg::CW'(b2);
			d    = yy - lim;
		end
		l.dy = (d > rrsg_pkg::HW'(l.r2)) ? l.r2 : rrsg_pkg::CW'(d);
		return l;
	endfunction

	always_comb begin
		y2        = (rrsg_pkg::HW'(row) << (rrsg_pkg::FB + 1)) + (rrsg_pkg::HW'(1) << rrsg_pkg::FB);
		rowfx     = rrsg_pkg::HW'(row) << rrsg_pkg::FB;
		bw2       = rrsg_pkg::HW'(cfg.bw) << 1;
		collapsed = (rrsg_pkg::HW'(cfg.w) <= bw2) || (rrsg_pkg::HW'(cfg.h) <= bw2);
		ih        = rrsg_pkg::HW'(cfg.h) - bw2;
		iy2       = y2 - bw2;
		lanes[rrsg_pkg::L_OL] = band(shape.outer[rrsg_pkg::TL], shape.outer[rrsg_pkg::BL],
			rrsg_pkg::HW'(cfg.h), y2);
		lanes[rrsg_pkg::L_OR] = band(shape.outer[rrsg_pkg::TR], shape.outer[rrsg_pkg::BR],
			rrsg_pkg::HW'(cfg.h), y2);
		lanes[rrsg_pkg::L_IL] = band(shape.inner[rrsg_pkg::TL], shape.inner[rrsg_pkg::BL], ih, iy2);
		lanes[rrsg_pkg::L_IR] = band(shape.inner[rrsg_pkg::TR], shape.inner[rrsg_pkg::BR], ih, iy2);
		cls.drop   = (cfg.w == '0) || (cfg.h == '0) || (rowfx >= rrsg_pkg::HW'(cfg.h)) ||
			(kind && cfg.bw == '0);
		// Rows above or below the inner box take the whole outer cross-section.
		cls.single = !kind || collapsed || (y2 < bw2) ||
			(y2 > (rrsg_pkg::HW'(cfg.h) << 1) - bw2);
		for (int i = 0; i < 4; i++) begin
			cls.r2[i] = lanes[i].r2;
			cls.dy[i] = lanes[i].dy;
		end
	end

	assign full  = !shape.ready || (cnt_q == (rrsg_pkg::FQW+1)'(rrsg_pkg::FQ_DEPTH));
	assign acc   = push && !full;
	assign avail = cnt_q != '0;
	assign job   = fq_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (acc) begin
				wr_q <= wr_q + rrsg_pkg::FQW'(1);
			end
			if (deq) begin
				rd_q <= rd_q + rrsg_pkg::FQW'(1);
			end
			cnt_q <= cnt_q + (rrsg_pkg::FQW+1)'(acc) - (rrsg_pkg::FQW+1)'(deq);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			fq_q[wr_q] <= cls;
		end
	end

endmodule

FILE: hdl/rrsg_isqrt.sv
// Pipelined integer square root, one result bit per stage, rounded down.
module rrsg_isqrt (
	input  logic                       clk,
	input  logic [2*rrsg_pkg::CW-1:0]  rad,
	output rrsg_pkg::coord_t           root
);

	logic [rrsg_pkg::CW:0]       rem_q  [rrsg_pkg::CW];
	logic [rrsg_pkg::CW-1:0]     root_q [rrsg_pkg::CW];
	logic [2*rrsg_pkg::CW-1:0]   src_q  [rrsg_pkg::CW];
	logic [rrsg_pkg::CW:0]       rem_in [rrsg_pkg::CW];
	logic [rrsg_pkg::CW-1:0]     root_in[rrsg_pkg::CW];
	logic [2*rrsg_pkg::CW-1:0]   src_in [rrsg_pkg::CW];

	for (genvar j = 0; j < rrsg_pkg::CW; j++) begin : g_stage
		logic [rrsg_pkg::CW+2:0] t;
		logic [rrsg_pkg::CW+2:0] trial;
		logic                    take;

		if (j == 0) begin : g_first
			assign rem_in[j]  = '0;
			assign root_in[j] = '0;
			assign src_in[j]  = rad;
		end else begin : g_next
			assign rem_in[j]  = rem_q[j-1];
			assign root_in[j] = root_q[j-1];
			assign src_in[j]  = src_q[j-1];
		end

		always_comb begin
			t     = {rem_in[j], src_in[j][2*rrsg_pkg::CW-1 -: 2]};
			trial = (rrsg_pkg::CW+3)'({root_in[j], 2'b01});
			take  = t >= trial;
		end

		always_ff @(posedge clk) begin
			rem_q[j]  <= take ? (rrsg_pkg::CW+1)'(t - trial) : t[rrsg_pkg::CW:0];
			root_q[j] <= {root_in[j][rrsg_pkg::CW-2:0], take};
			src_q[j]  <= {src_in[j][2*rrsg_pkg::CW-3:0], 2'b00};
		end
	end

	assign root = root_q[rrsg_pkg::CW-1];

endmodule

FILE: hdl/rrsg_back.sv
// Back end: corner offsets through the root lanes, span edges and the result queue.
module rrsg_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             avail,
	input  rrsg_pkg::job_t   job,
	output logic             deq,
	input  rrsg_pkg::cfg_t   cfg,
	input  logic             pop,
	output logic             empty,
	output rrsg_pkg::coord_t span_start,
	output rrsg_pkg::coord_t span_end,
	output logic             last
);

	typedef struct packed {
		logic [1:0]       n;
		rrsg_pkg::coord_t s0;
		rrsg_pkg::coord_t e0;
		rrsg_pkg::coord_t s1;
		rrsg_pkg::coord_t e1;
	} spans_t;

	logic [rrsg_pkg::LAT-1:0]   v_q;
	rrsg_pkg::job_t             meta_q [rrsg_pkg::LAT];
	logic [2*rrsg_pkg::CW-1:0]  sq_r_s1 [4];
	logic [2*rrsg_pkg::CW-1:0]  sq_d_s1 [4];
	logic [2*rrsg_pkg::CW-1:0]  rad_s2  [4];
	rrsg_pkg::coord_t           dx [4];

	spans_t                     mem_q [rrsg_pkg::DEPTH];
	logic [rrsg_pkg::DPW-1:0]   wp_q;
	logic [rrsg_pkg::DPW-1:0]   rp_q;
	logic                       sub_q;
	logic [rrsg_pkg::DPW:0]     fcnt_q;
	logic [rrsg_pkg::DPW:0]     infl_q;

	rrsg_pkg::job_t             ex;
	logic                       ex_v;
	logic [rrsg_pkg::EW-1:0]    xlo, xro, xli, xri, iw;
	logic                       ring, a_ok, b_ok;
	spans_t                     wr_sp;
	logic                       wr;
	spans_t                     cur;
	logic                       pop_ok;
	logic                       pop_end;

	// Each job reserves one queue entry before it enters the pipeline.
	assign deq = avail && ((rrsg_pkg::DPW+2)'(fcnt_q) + (rrsg_pkg::DPW+2)'(infl_q) <
		(rrsg_pkg::DPW+2)'(rrsg_pkg::DEPTH));

	for (genvar i = 0; i < 4; i++) begin : g_lane
		rrsg_isqrt u_isqrt (
			.clk  (clk),
			.rad  (rad_s2[i]),
			.root (dx[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[rrsg_pkg::LAT-2:0], deq};
		end
	end

	always_ff @(posedge clk) begin
		meta_q[0] <= job;
		for (int k = 1; k < rrsg_pkg::LAT; k++) begin
			meta_q[k] <= meta_q[k-1];
		end
		for (int i = 0; i < 4; i++) begin
			sq_r_s1[i] <= (2*rrsg_pkg::CW)'(job.r2[i]) * (2*rrsg_pkg::CW)'(job.r2[i]);
			sq_d_s1[i] <= (2*rrsg_pkg::CW)'(job.dy[i]) * (2*rrsg_pkg::CW)'(job.dy[i]);
			rad_s2[i]  <= sq_r_s1[i] - sq_d_s1[i];
		end
	end

	always_comb begin
		ex   = meta_q[rrsg_pkg::LAT-1];
		ex_v = v_q[rrsg_pkg::LAT-1];
		iw   = rrsg_pkg::EW'(cfg.w) - (rrsg_pkg::EW'(cfg.bw) << 1);
		xlo  = (rrsg_pkg::EW'(ex.r2[rrsg_pkg::L_OL]) - rrsg_pkg::EW'(dx[rrsg_pkg::L_OL])) >> 1;
		xro  = ((rrsg_pkg::EW'(cfg.w) << 1) - rrsg_pkg::EW'(ex.r2[rrsg_pkg::L_OR]) +
			rrsg_pkg::EW'(dx[rrsg_pkg::L_OR])) >> 1;
		xli  = rrsg_pkg::EW'(cfg.bw) + ((rrsg_pkg::EW'(ex.r2[rrsg_pkg::L_IL]) -
			rrsg_pkg::EW'(dx[rrsg_pkg::L_IL])) >> 1);
		xri  = rrsg_pkg::EW'(cfg.bw) + (((iw << 1) - rrsg_pkg::EW'(ex.r2[rrsg_pkg::L_IR]) +
			rrsg_pkg::EW'(dx[rrsg_pkg::L_IR])) >> 1);
		ring = !ex.single && (xri > xli);
		a_ok = xli > xlo;
		b_ok = xro > xri;
		wr_sp.s1 = rrsg_pkg::CW'(xri);
		wr_sp.e1 = rrsg_pkg::CW'(xro);
		if (ex.drop) begin
			wr_sp.n  = 2'd0;
			wr_sp.s0 = rrsg_pkg::CW'(xlo);
			wr_sp.e0 = rrsg_pkg::CW'(xro);
		end else if (!ring) begin
			wr_sp.n  = (xro > xlo) ? 2'd1 : 2'd0;
			wr_sp.s0 = rrsg_pkg::CW'(xlo);
			wr_sp.e0 = rrsg_pkg::CW'(xro);
		end else begin
			// An empty left ring span moves the right one into the first slot.
			wr_sp.n  = 2'(a_ok) + 2'(b_ok);
			wr_sp.s0 = a_ok ? rrsg_pkg::CW'(xlo) : rrsg_pkg::CW'(xri);
			wr_sp.e0 = a_ok ? rrsg_pkg::CW'(xli) : rrsg_pkg::CW'(xro);
		end
		wr = ex_v && (wr_sp.n != 2'd0);
	end

	assign cur        = mem_q[rp_q];
	assign empty      = fcnt_q == '0;
	assign span_start = sub_q ? cur.s1 : cur.s0;
	assign span_end   = sub_q ? cur.e1 : cur.e0;
	assign last       = sub_q || (cur.n == 2'd1);
	assign pop_ok     = pop && !empty;
	assign pop_end    = pop_ok && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			sub_q  <= 1'b0;
			fcnt_q <= '0;
			infl_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + rrsg_pkg::DPW'(1);
			end
			if (pop_ok) begin
				sub_q <= !last;
			end
			if (pop_end) begin
				rp_q <= rp_q + rrsg_pkg::DPW'(1);
			end
			fcnt_q <= fcnt_q + (rrsg_pkg::DPW+1)'(wr) - (rrsg_pkg::DPW+1)'(pop_end);
			infl_q <= infl_q + (rrsg_pkg::DPW+1)'(deq) - (rrsg_pkg::DPW+1)'(ex_v);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_sp;
		end
	end

endmodule

FILE: hdl/rounded_rect_span_generator_top.sv
// Top level of the rounded box span generator: registers, normalizer, front and back ends.
//
//   channel   direction  handshake               payload
//   input     in         push / full             row, kind
//   results   out        pop / empty             span_start, span_end, last
//   config    in         cfg_we                  cfg_index, cfg_data
//
// One row request is accepted per cycle while full is low; its spans reach the result queue
// through the front queue and the one-bit-per-stage square root lanes. Spans leave one per pop, so rows
// with two ring spans take two pops each. A register write starts the radius normalizer,
// which holds full high while it scales the radii with its bit-serial
// divider. Reset clears all registers and radii and leaves the block ready at once.
// Full also rises when the request queue fills behind a result queue with no unreserved entry.
module rounded_rect_span_generator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [rrsg_pkg::ROW_W-1:0]  row,
	input  logic                        kind,
	input  logic                        pop,
	output logic                        empty,
	output logic [rrsg_pkg::CW-1:0]     span_start,
	output logic [rrsg_pkg::CW-1:0]     span_end,
	output logic                        last,
	input  logic                        cfg_we,
	input  logic [rrsg_pkg::IDX_W-1:0]  cfg_index,
	input  logic [rrsg_pkg::CW-1:0]     cfg_data
);

	rrsg_pkg::cfg_t   cfg_q;
	rrsg_pkg::shape_t shape;
	rrsg_pkg::job_t   job;
	logic             start;
	logic             avail;
	logic             deq;

	assign start = cfg_we && (cfg_index < rrsg_pkg::IDX_W'(rrsg_pkg::NREG));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rrsg_pkg::REG_BOX_W:  cfg_q.w <= cfg_data;
				rrsg_pkg::REG_BOX_H:  cfg_q.h <= cfg_data;
				rrsg_pkg::REG_RAD_TL: cfg_q.req[rrsg_pkg::TL] <= cfg_data;
				rrsg_pkg::REG_RAD_TR: cfg_q.req[rrsg_pkg::TR] <= cfg_data;
				rrsg_pkg::REG_RAD_BR: cfg_q.req[rrsg_pkg::BR] <= cfg_data;
				rrsg_pkg::REG_RAD_BL: cfg_q.req[rrsg_pkg::BL] <= cfg_data;
				rrsg_pkg::REG_BORDER: cfg_q.bw <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rrsg_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cfg    (cfg_q),
		.shape  (shape)
	);

	rrsg_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.row    (row),
		.kind   (kind),
		.full   (full),
		.cfg    (cfg_q),
		.shape  (shape),
		.deq    (deq),
		.avail  (avail),
		.job    (job)
	);

	rrsg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.avail      (avail),
		.job        (job),
		.deq        (deq),
		.cfg        (cfg_q),
		.pop        (pop),
		.empty      (empty),
		.span_start (span_start),
		.span_end   (span_end),
		.last       (last)
	);

	// A register write must hold off requests until the radii are normalized again.
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> full) else $error("request path open after register write");

	a_norm_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!shape.ready |-> full) else $error("request accepted during normalization");

	// The second span of a ring row is already queued when the first one leaves.
	a_pair_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last) |=> !empty) else $error("second ring span missing");

endmodule
